FILE: hw/rtl/am_duty_noise_shaper_defines.svh
// Assertion macros for the AM duty noise shaper.
// Used by modules that check their own logic; no other dependencies.
`ifndef AM_DUTY_NOISE_SHAPER_DEFINES_SVH
`define AM_DUTY_NOISE_SHAPER_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is active
`define AM_DNS_ASSERT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is active
`define AM_DNS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define AM_DNS_ASSERT(lbl, pre, post)
`define AM_DNS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: hw/rtl/am_dns_pkg.sv
// Shared types and constants for the AM duty noise shaper.
// No dependencies.
package am_dns_pkg;

    localparam int TABLE_DEPTH   = 512;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int ERR_W         = 14;
    localparam int ERR_LIMIT     = 4096;
    localparam int SAMPLE_OFFSET = 32768;
    localparam int DECAY_SHIFT   = 6;
    localparam int FRAC_BITS     = 8;
    localparam int DUTY_LO       = 1;
    localparam int DUTY_HI       = 255;

    // Operation codes
    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_TABLE_WR = 1'b1;

    // Configuration register indexes
    localparam logic CFG_OUTPUT_ENABLE  = 1'b0;
    localparam logic CFG_SHAPING_ENABLE = 1'b1;

    typedef logic signed [ERR_W-1:0] t_err;

    // Quantizer result passed back to the top level
    typedef struct packed {
        logic [7:0] duty;
        t_err       err;
    } t_quant_res;

endpackage

FILE: hw/rtl/am_dns_quant.sv
// Duty quantizer: adds fed-back error when shaping is enabled, clamps the duty, bounds the new error.
// Depends on am_dns_pkg.
module am_dns_quant (
    input  logic [15:0]            i_table_data,
    input  am_dns_pkg::t_err       i_err,
    input  logic                   i_shaping_en,
    output am_dns_pkg::t_quant_res o_res
);
    import am_dns_pkg::*;

    logic signed [17:0] q;
    logic signed [9:0]  dsh;
    logic [7:0]         duty;
    logic signed [18:0] e_full;

    always_comb begin
        // Table value plus optional error feedback
        q = $signed({2'b00, i_table_data});
        if (i_shaping_en) begin
            q = q + {{(18-ERR_W){i_err[ERR_W-1]}}, i_err};
        end

        // Integer part, floor toward minus infinity, then clamp
        dsh = q[17:FRAC_BITS];
        if (dsh < 10'(DUTY_LO)) begin
            duty = 8'(DUTY_LO);
        end else if (dsh > 10'(DUTY_HI)) begin
            duty = 8'(DUTY_HI);
        end else begin
            duty = dsh[7:0];
        end

        // Leftover error, bounded
        e_full = {q[17], q} - $signed({3'b000, duty, 8'h00});
        if (e_full > 19'(ERR_LIMIT)) begin
            o_res.err = ERR_W'(ERR_LIMIT);
        end else if (e_full < -19'(ERR_LIMIT)) begin
            o_res.err = -ERR_W'(ERR_LIMIT);
        end else begin
            o_res.err = e_full[ERR_W-1:0];
        end
        o_res.duty = duty;
    end

endmodule

FILE: hw/rtl/am_duty_noise_shaper.sv
// Top level of the AM duty noise shaper: sample path, duty table, pipeline.
// Depends on am_dns_pkg, am_dns_quant and am_duty_noise_shaper_defines.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries either a modulation tick
//   (audio sample or underrun flag) or a duty table write. A table write gives
//   no result; a tick gives one result on the output channel
//   (o_out_valid / i_out_stall): duty 1..255, duty write strobe, underrun flag
//   and the running underrun count.
//   The table read register loads at a tick's transfer edge and the quantized
//   result then loads into the output register when the pipeline advances,
//   where it is offered until the receiver takes it. Throughput: one item per
//   cycle while the receiver does not stall; the error feedback add-and-clamp
//   is combinational.
//   Table writes take effect for the next transferred tick.
//   Reset clears the error, the last sample and the underrun count, sets both
//   enables and empties the pipeline; the table keeps no defined contents and
//   must be loaded before ticks index it.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   o_in_stall is raised until the result is taken.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data;
//   the user must write it only while the block is idle (not enforced).
`include "am_duty_noise_shaper_defines.svh"
module am_duty_noise_shaper (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic               i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic               i_sample_valid,
    input  logic signed [15:0] i_audio_sample,
    input  logic [8:0]         i_table_index,
    input  logic [15:0]        i_table_value,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_duty,
    output logic               o_duty_write,
    output logic               o_underrun,
    output logic [31:0]        o_underrun_count
);
    import am_dns_pkg::*;

    // Configuration registers
    logic r_out_en;
    logic r_shape_en;

    // Loop state
    logic signed [15:0] r_prev;
    logic [31:0]        r_ucnt;
    t_err               r_err;

    // Stage 1: table read in flight
    logic               r_s1_valid;
    logic               r_s1_under;
    logic [31:0]        r_s1_ucnt;
    logic [15:0]        r_rd_data;

    // Output register
    logic               r_out_valid;
    logic [7:0]         r_out_duty;
    logic               r_out_dw;
    logic               r_out_under;
    logic [31:0]        r_out_ucnt;

    // Duty table
    logic [15:0] r_mem [TABLE_DEPTH];

    logic               advance;
    logic               in_xfer;
    logic               tick_xfer;
    logic               twr_xfer;
    logic               wr_in_range;
    logic signed [15:0] n_sample;
    logic [31:0]        n_ucnt;
    logic [15:0]        offs;
    logic [16+IDX_W:0]  prod;
    logic [IDX_W-1:0]   rd_idx;
    t_quant_res         qres;

    // Handshake: pipeline moves whenever the output register can take data
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = !advance || !i_rst_n;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign tick_xfer  = in_xfer && (i_operation == OP_TICK);
    assign twr_xfer   = in_xfer && (i_operation == OP_TABLE_WR);
    assign wr_in_range = 32'(i_table_index) < TABLE_DEPTH;

    // Sample select with decay on underrun, and table index scaling
    always_comb begin
        if (i_sample_valid) begin
            n_sample = i_audio_sample;
            n_ucnt   = r_ucnt;
        end else begin
            n_sample = r_prev - (r_prev >>> DECAY_SHIFT);
            n_ucnt   = r_ucnt + 32'd1;
        end
        offs   = 16'(17'($unsigned(n_sample)) + 17'(SAMPLE_OFFSET));
        prod   = (17+IDX_W)'(offs) * (17+IDX_W)'(TABLE_DEPTH);
        rd_idx = prod[16 +: IDX_W];
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_en   <= 1'b1;
            r_shape_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OUTPUT_ENABLE:  r_out_en   <= i_cfg_data;
                CFG_SHAPING_ENABLE: r_shape_en <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Duty table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (twr_xfer && wr_in_range) begin
            r_mem[IDX_W'(i_table_index)] <= i_table_value;
        end
        if (tick_xfer) begin
            r_rd_data <= r_mem[rd_idx];
        end
    end

    // Stage 1 control and sample state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_ucnt     <= '0;
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= tick_xfer;
            if (tick_xfer) begin
                r_prev <= n_sample;
                r_ucnt <= n_ucnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_xfer) begin
            r_s1_under <= !i_sample_valid;
            r_s1_ucnt  <= n_ucnt;
        end
    end

    am_dns_quant u_quant (
        .i_table_data (r_rd_data),
        .i_err        (r_err),
        .i_shaping_en (r_shape_en),
        .o_res        (qres)
    );

    // Output register and error feedback
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_err       <= '0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid && r_shape_en) begin
                r_err <= qres.err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_duty  <= qres.duty;
            r_out_dw    <= r_out_en;
            r_out_under <= r_s1_under;
            r_out_ucnt  <= r_s1_ucnt;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_duty           = r_out_duty;
    assign o_duty_write     = r_out_dw;
    assign o_underrun       = r_out_under;
    assign o_underrun_count = r_out_ucnt;

    // Checks
    `AM_DNS_ASSERT(a_duty_nonzero, r_out_valid, r_out_duty != 8'd0)
    `AM_DNS_ASSERT(a_err_bounded, 1'b1,
        (r_err <= ERR_W'(ERR_LIMIT)) && (r_err >= -ERR_W'(ERR_LIMIT)))
    `AM_DNS_ASSERT_NEXT(a_ucnt_inc, tick_xfer && !i_sample_valid,
        r_ucnt == $past(r_ucnt) + 32'd1)
    `AM_DNS_ASSERT(a_stall_blocks_input, r_out_valid && i_out_stall, o_in_stall)
    `AM_DNS_ASSERT_NEXT(a_s1_holds, r_s1_valid && !advance, r_s1_valid)

endmodule

FILE: tb/am_duty_noise_shaper_tb.sv
// Self-checking testbench for am_duty_noise_shaper: bursty sender, stalling receiver,
// an in-bench duty/error-feedback predictor and a result scoreboard.
// Depends on am_dns_pkg and the am_duty_noise_shaper RTL.
`timescale 1ns / 100ps

module am_duty_noise_shaper_tb;
    import am_dns_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 240;
    localparam int HOLD_AFTER     = 200;

    // One input transfer: a modulation tick or a table word write
    typedef struct packed {
        logic               op;
        logic               smp_valid;
        logic signed [15:0] sample;
        logic [8:0]         slot;
        logic [15:0]        word;
    } t_shaper_item;

    // One output transfer
    typedef struct packed {
        logic [7:0]  duty;
        logic        duty_write;
        logic        underrun;
        logic [31:0] underrun_count;
    } t_duty_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = CFG_OUTPUT_ENABLE;
    logic               i_cfg_data = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_operation = OP_TICK;
    logic               i_sample_valid = 1'b0;
    logic signed [15:0] i_audio_sample = '0;
    logic [8:0]         i_table_index = '0;
    logic [15:0]        i_table_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [7:0]         o_duty;
    logic               o_duty_write;
    logic               o_underrun;
    logic [31:0]        o_underrun_count;

    am_duty_noise_shaper dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_sample_valid   (i_sample_valid),
        .i_audio_sample   (i_audio_sample),
        .i_table_index    (i_table_index),
        .i_table_value    (i_table_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_duty           (o_duty),
        .o_duty_write     (o_duty_write),
        .o_underrun       (o_underrun),
        .o_underrun_count (o_underrun_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Items waiting to be offered and duties waiting to come out
    t_shaper_item pending_items[$];
    t_duty_result expected_duties[$];

    // Predictor state
    logic [15:0] mdl_table [TABLE_DEPTH];
    int          mdl_err = 0;
    int          mdl_last = 0;
    logic [31:0] mdl_underruns = '0;
    logic        mdl_out_en = 1'b1;
    logic        mdl_shape_en = 1'b1;

    // Generator's view of the sample history, so ticks only hit loaded entries
    bit          gen_loaded [TABLE_DEPTH];
    int          gen_last = 0;

    int n_ticks = 0;
    int n_writes = 0;
    int n_results = 0;
    int n_mismatch = 0;
    int n_settings = 1;
    bit hold_done = 1'b0;

    // Last sample decayed by 1/64, shift rounds toward minus infinity
    function automatic int decayed(input int s);
        return s - (s >>> DECAY_SHIFT);
    endfunction

    function automatic int table_slot(input int s);
        int slot;
        slot = ((s + SAMPLE_OFFSET) * TABLE_DEPTH) >>> 16;
        return (slot >= TABLE_DEPTH) ? TABLE_DEPTH - 1 : slot;
    endfunction

    // Duty words biased toward both clamp ends
    function automatic logic [15:0] pick_duty_word();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(255));
            1:       return 16'hFF00 | 16'($urandom_range(255));
            default: return 16'($urandom());
        endcase
    endfunction

    // Predictor: table write or tick, expected duty pushed for ticks
    task automatic predict_item(input t_shaper_item it);
        int smp;
        int q;
        int duty;
        int e;
        t_duty_result r;
        if (it.op == OP_TABLE_WR) begin
            if (it.slot < TABLE_DEPTH)
                mdl_table[it.slot] = it.word;
            n_writes++;
            return;
        end
        n_ticks++;
        if (it.smp_valid) begin
            smp = $signed(it.sample);
        end else begin
            smp = decayed(mdl_last);
            mdl_underruns = mdl_underruns + 1;
        end
        mdl_last = smp;
        q = int'(mdl_table[table_slot(smp)]);
        if (mdl_shape_en)
            q += mdl_err;
        duty = q >>> FRAC_BITS;
        if (duty < DUTY_LO) duty = DUTY_LO;
        if (duty > DUTY_HI) duty = DUTY_HI;
        if (mdl_shape_en) begin
            e = q - duty * (1 << FRAC_BITS);
            if (e > ERR_LIMIT) e = ERR_LIMIT;
            if (e < -ERR_LIMIT) e = -ERR_LIMIT;
            mdl_err = e;
        end
        r.duty           = duty[7:0];
        r.duty_write     = mdl_out_en;
        r.underrun       = !it.smp_valid;
        r.underrun_count = mdl_underruns;
        expected_duties.push_back(r);
    endtask

    task automatic queue_table_word(input int slot, input logic [15:0] word);
        t_shaper_item it;
        it.op        = OP_TABLE_WR;
        it.smp_valid = 1'($urandom());
        it.sample    = 16'($urandom());
        it.slot      = slot[8:0];
        it.word      = word;
        gen_loaded[slot] = 1'b1;
        pending_items.push_back(it);
    endtask

    // Tick; loads the entry it will read first if it was never written
    task automatic queue_tick(input bit valid, input int smp);
        t_shaper_item it;
        int eff;
        int slot;
        it.op        = OP_TICK;
        it.smp_valid = valid;
        it.sample    = smp[15:0];
        it.slot      = 9'($urandom());
        it.word      = 16'($urandom());
        eff  = valid ? int'($signed(it.sample)) : decayed(gen_last);
        slot = table_slot(eff);
        if (!gen_loaded[slot])
            queue_table_word(slot, pick_duty_word());
        gen_last = eff;
        pending_items.push_back(it);
    endtask

    function automatic int any_sample();
        return int'($urandom_range(65535)) - SAMPLE_OFFSET;
    endfunction

    // Random traffic: mostly ticks, with underrun runs and clamp runs mixed in
    task automatic queue_random_traffic(input int n);
        int count;
        int len;
        int kind;
        bit hi;
        count = 0;
        while (count < n) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                queue_tick($urandom_range(9) != 0, any_sample());
                count++;
            end else if (kind < 70) begin
                len = $urandom_range(2, 8);
                repeat (len) queue_tick(1'b0, any_sample());
                count += len;
            end else if (kind < 80) begin
                // run at one table end long enough to saturate the error
                hi  = 1'($urandom());
                len = $urandom_range(12, 24);
                queue_table_word(hi ? TABLE_DEPTH - 1 : 0, hi ? 16'hFFFF : 16'h0000);
                repeat (len) queue_tick(1'b1, hi ? 32767 : -32768);
                count += len + 1;
            end else begin
                queue_table_word($urandom_range(TABLE_DEPTH - 1), pick_duty_word());
                count++;
            end
        end
    endtask

    // Wait until everything offered has been checked, then let the pipe settle
    task automatic drain_block();
        while (pending_items.size() != 0 || expected_duties.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_registers(input logic out_en, input logic shape_en);
        drain_block();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_OUTPUT_ENABLE;
        i_cfg_data  <= out_en;
        @(posedge i_clk);
        i_cfg_index <= CFG_SHAPING_ENABLE;
        i_cfg_data  <= shape_en;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mdl_out_en   = out_en;
        mdl_shape_en = shape_en;
        n_settings++;
    endtask

    // Stimulus sequence
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: clamp ends, negative sums, decay rounding, overwrite
        queue_table_word(0, 16'h0000);
        queue_tick(1'b1, -32768);
        queue_tick(1'b1, -32768);
        queue_table_word(TABLE_DEPTH - 1, 16'hFFFF);
        queue_tick(1'b1, 32767);
        queue_tick(1'b1, 32767);
        queue_table_word(TABLE_DEPTH / 2, 16'h8080);
        queue_tick(1'b1, 0);
        queue_tick(1'b0, 32767);
        queue_tick(1'b1, 32767);
        queue_tick(1'b0, 0);
        queue_tick(1'b0, -1);
        queue_tick(1'b1, -1);
        queue_tick(1'b0, 0);
        queue_tick(1'b1, -100);
        queue_tick(1'b0, 0);
        queue_tick(1'b1, -32768);
        queue_tick(1'b0, 0);
        queue_table_word(TABLE_DEPTH / 2, 16'h0180);
        queue_tick(1'b1, 0);

        queue_random_traffic(120);
        set_registers(1'b0, 1'b0);
        queue_random_traffic(105);
        set_registers(1'b1, 1'b0);
        queue_random_traffic(105);
        set_registers(1'b0, 1'b1);
        queue_random_traffic(105);
        set_registers(1'b1, 1'b1);
        queue_random_traffic(105);

        drain_block();
        repeat (8) @(posedge i_clk);
        $display("Summary: %0d ticks (%0d underruns) and %0d table writes",
                 n_ticks, mdl_underruns, n_writes);
        $display("Summary: %0d register settings, %0d results checked, long hold-off %s",
                 n_settings, n_results, hold_done ? "exercised" : "not reached");
        if (n_mismatch == 0)
            $display("am_duty_noise_shaper verification clean");
        else
            $display("am_duty_noise_shaper verification failed");
        $finish;
    end

    // Sender: bursts of transfers separated by random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid)
                predict_item(pending_items.pop_front());
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                i_in_valid     <= 1'b1;
                i_operation    <= pending_items[0].op;
                i_sample_valid <= pending_items[0].smp_valid;
                i_audio_sample <= pending_items[0].sample;
                i_table_index  <= pending_items[0].slot;
                i_table_value  <= pending_items[0].word;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall density changes per segment, plus one long hold-off
    int seg_left = 0;
    int stall_pct = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && n_results >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 150);
                case ($urandom_range(4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 50;
                    default: stall_pct = 80;
                endcase
            end
            seg_left--;
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Scoreboard: each result against the oldest expected duty
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            n_mismatch++;
        end
    endtask

    t_duty_result want_res;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (expected_duties.size() == 0) begin
                $display("%0t: unexpected result: expected none, got duty %0d",
                         $time, o_duty);
                n_mismatch++;
            end else begin
                want_res = expected_duties.pop_front();
                check_field("duty", want_res.duty, o_duty);
                check_field("duty_write", want_res.duty_write, o_duty_write);
                check_field("underrun", want_res.underrun, o_underrun);
                check_field("underrun_count", want_res.underrun_count, o_underrun_count);
            end
        end
    end

    // Watchdog: too long without any transfer on either channel
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("am_duty_noise_shaper verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
